### rtl/core/sitoa_pkg.sv
// Shared constants and the digit-to-ASCII function for the signed integer to ASCII converter.
`default_nettype none

package sitoa_pkg;

    typedef logic [1:0] mode_t;
    typedef logic [6:0] ascii_t;

    localparam mode_t MODE_DEC = 2'd0;
    localparam mode_t MODE_HEX = 2'd1;
    localparam mode_t MODE_BIN = 2'd2;

    localparam ascii_t ASCII_ZERO  = 7'h30;
    localparam ascii_t ASCII_A     = 7'h41;
    localparam ascii_t ASCII_MINUS = 7'h2D;

    function automatic ascii_t digit_char(input logic [3:0] d);
        ascii_t c;
        if (d > 4'd9)
        begin
            c = ASCII_A + 7'(d) - 7'd10;
        end
        else
        begin
            c = ASCII_ZERO + 7'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/signed_integer_to_ascii_radix_top.sv
// Signed integer to ASCII converter: sequencer, shift-and-add-3 unit and output register.
// A transaction on the input carries one two's-complement value and a radix mode (decimal,
// uppercase hexadecimal, binary; mode 3 acts as decimal). The block emits one output
// transaction per character, most significant first, with a leading '-' for negative values,
// leading zeros suppressed, and last set on the final character. One item is converted at a
// time and in_ready is low until its final character is loaded into the output register.
// Decimal first runs the shift-and-add-3 conversion over every bit of the value and then steps
// through the BCD digit slots; hexadecimal steps through the nibbles and binary through the bits;
// a negative value emits the '-' before its digits.
`default_nettype none

module signed_integer_to_ascii_radix_top #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire sitoa_pkg::mode_t         mode,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output sitoa_pkg::ascii_t             character,
    output logic                          last
);
    import sitoa_pkg::*;

    localparam int DEC_DIGITS  = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int HEX_DIGITS  = (VALUE_BITS + 3) / 4;
    localparam int WORK_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int WORK_W      = WORK_DIGITS * 4;
    localparam int HEX_W       = HEX_DIGITS * 4;
    localparam int CNT_W       = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DABBLE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  sign_reg, sign_next;
    logic                  started_reg, started_next;
    logic                  out_valid_reg, out_valid_next;
    mode_t                 mode_reg, mode_next;
    logic [WORK_W-1:0]     work_reg, work_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    ascii_t                char_reg, char_next;
    logic                  last_reg, last_next;

    logic                  slot_free;
    logic                  final_slot;
    logic                  emit_fire;
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] mag;
    logic [WORK_W-1:0]     adj;
    logic [WORK_W-1:0]     work_shift;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;
    assign slot_free  = !out_valid_reg || out_ready;
    assign final_slot = (cnt_reg == CNT_W'(1));
    assign digit      = (mode_reg == MODE_BIN) ? {3'b000, work_reg[WORK_W-1]}
                                               : work_reg[WORK_W-1 -: 4];
    assign mag        = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
    assign work_shift = (mode_reg == MODE_BIN) ? (work_reg << 1) : (work_reg << 4);

    always_comb
    begin
        for (int i = 0; i < WORK_DIGITS; i++)
        begin
            if (work_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = work_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = work_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sign_next      = sign_reg;
        started_next   = started_reg;
        mode_next      = mode_reg;
        work_next      = work_reg;
        bin_next       = bin_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        emit_fire      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sign_next    = value[VALUE_BITS-1];
                    started_next = 1'b0;
                    mode_next    = mode;
                    if (mode == MODE_HEX)
                    begin
                        work_next  = WORK_W'(HEX_W'(mag)) << (WORK_W - HEX_W);
                        cnt_next   = CNT_W'(HEX_DIGITS);
                        state_next = ST_EMIT;
                    end
                    else if (mode == MODE_BIN)
                    begin
                        work_next  = WORK_W'(mag) << (WORK_W - VALUE_BITS);
                        cnt_next   = CNT_W'(VALUE_BITS);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        work_next  = '0;
                        bin_next   = mag;
                        cnt_next   = CNT_W'(VALUE_BITS);
                        state_next = ST_DABBLE;
                    end
                end
            end
            ST_DABBLE:
            begin
                work_next = {adj[WORK_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next  = bin_reg << 1;
                if (final_slot)
                begin
                    cnt_next   = CNT_W'(WORK_DIGITS);
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (sign_reg)
                begin
                    if (slot_free)
                    begin
                        char_next      = ASCII_MINUS;
                        last_next      = 1'b0;
                        out_valid_next = 1'b1;
                        sign_next      = 1'b0;
                    end
                end
                else if ((digit == 4'd0) && !started_reg && !final_slot)
                begin
                    work_next = work_shift;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
                else if (slot_free)
                begin
                    emit_fire      = 1'b1;
                    char_next      = digit_char(digit);
                    last_next      = final_slot;
                    out_valid_next = 1'b1;
                    started_next   = 1'b1;
                    work_next      = work_shift;
                    cnt_next       = cnt_reg - CNT_W'(1);
                    if (final_slot)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sign_reg      <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sign_reg      <= sign_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        work_reg <= work_next;
        bin_reg  <= bin_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    a_final_char_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && final_slot) |=> (state_reg == ST_IDLE))
        else $error("final character loaded but sequencer did not return to idle");

    a_dabble_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DABBLE) |-> (cnt_reg != '0))
        else $error("conversion step counter reached zero while converting");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (char_reg == ASCII_MINUS)) |-> !last_reg)
        else $error("minus sign flagged as the final character");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted transaction");

endmodule

`default_nettype wire
